// ===== rtl/okvt_pkg.sv =====
package okvt_pkg;

  // command codes of the input beat
  typedef enum logic [2:0] {
    CMD_SET            = 3'd0,
    CMD_LOOKUP         = 3'd1,
    CMD_REMOVE_KEY     = 3'd2,
    CMD_REMOVE_VALUE   = 3'd3,
    CMD_KEYS_WITH_VAL  = 3'd4,
    CMD_SWAP           = 3'd5,
    CMD_CLEAR          = 3'd6
  } cmd_t;

  // per-cell update controls
  typedef struct packed {
    logic shift;   // take the contents of the right-hand neighbor
    logic wr_key;  // load the key write data
    logic wr_val;  // load the value write data
  } cell_ctrl_t;

  // per-cell compare results
  typedef struct packed {
    logic key;
    logic key2;
    logic val;
  } cell_hit_t;

endpackage

// ===== rtl/ordered_key_value_table.sv =====
// ordered key/value table, entries kept in insertion order
//
// input channel: in_valid / in_stall carry one command beat (cmd, key,
// second_key, value). result channel: out_valid / out_stall carry result
// beats; out_last marks the final beat of a command.
// storage is a row of CAPACITY cells, slot 0 oldest; removal shifts the
// cells right of a dropped entry one place left, all in the same cycle.
// command handling, one command at a time:
//   set, lookup, remove key, swap, clear: result beat registered
//   the cycle after acceptance
//   remove value: the row drops one matching entry per cycle until
//   no match is left, then the result beat follows
//   keys with value: one beat per matching key, oldest first
// the next command is taken once the previous one has finished and the
// output register is free or being drained.
// reset clears the entry count and the control state; the cell contents
// are left as they are and never read above the entry count.
// a stall on the result side holds the output beat and blocks new commands;
// a keys-with-value listing just pauses while stalled.
module ordered_key_value_table import okvt_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_second_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_value_out,
  output logic [31:0] out_key_out,
  output logic [4:0]  out_entry_count,
  output logic        out_full_error,
  output logic        out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_RMV, S_LIST} state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           occ_r, occ_nxt;
  logic [VALUE_WIDTH-1:0]  rmv_val_r, rmv_val_nxt;
  logic [CAPACITY-1:0]     pend_r, pend_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [31:0]             out_value_r, out_value_nxt;
  logic [31:0]             out_key_r, out_key_nxt;
  logic [4:0]              out_count_r, out_count_nxt;
  logic                    out_full_r, out_full_nxt;
  logic                    out_last_r, out_last_nxt;

  // incoming fields narrowed to the stored widths
  logic [KEY_WIDTH-1:0]    k_in, k2_in;
  logic [VALUE_WIDTH-1:0]  v_in, cmp_val;

  // cell row
  logic [KEY_WIDTH-1:0]    cell_key [CAPACITY];
  logic [VALUE_WIDTH-1:0]  cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0]  wr_val_d [CAPACITY];
  cell_hit_t               hit      [CAPACITY];
  cell_ctrl_t              ctrl     [CAPACITY];

  logic [CAPACITY-1:0]     vld, khit, k2hit, vhit, sel;
  logic [VALUE_WIDTH-1:0]  lk_val, sw_v1, sw_v2;
  logic [KEY_WIDTH-1:0]    sel_key;
  logic                    accept, out_free;

  assign k_in  = KEY_WIDTH'(in_key);
  assign k2_in = KEY_WIDTH'(in_second_key);
  assign v_in  = VALUE_WIDTH'(in_value);

  // remove value keeps comparing against the captured value
  assign cmp_val = (state_r == S_IDLE) ? v_in : rmv_val_r;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nb_key;
    logic [VALUE_WIDTH-1:0] nb_val;

    if (i == CAPACITY - 1) begin : g_end
      assign nb_key = cell_key[i];
      assign nb_val = cell_val[i];
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_val = cell_val[i+1];
    end

    okvt_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .wr_key_d (k_in),
      .wr_val_d (wr_val_d[i]),
      .nb_key   (nb_key),
      .nb_val   (nb_val),
      .cmp_key  (k_in),
      .cmp_key2 (k2_in),
      .cmp_val  (cmp_val),
      .key_q    (cell_key[i]),
      .val_q    (cell_val[i]),
      .hit      (hit[i])
    );

    // only slots below the entry count hold live entries
    assign vld[i]   = (CW'(i) < occ_r);
    assign khit[i]  = hit[i].key  && vld[i];
    assign k2hit[i] = hit[i].key2 && vld[i];
    assign vhit[i]  = hit[i].val  && vld[i];
  end

  // read-out muxes over the row; key hits are one-hot at most
  always_comb begin
    logic acc;
    lk_val  = '0;
    sw_v2   = '0;
    sel_key = '0;
    acc     = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      lk_val   = lk_val  | (cell_val[i] & {VALUE_WIDTH{khit[i]}});
      sw_v2    = sw_v2   | (cell_val[i] & {VALUE_WIDTH{k2hit[i]}});
      // oldest pending match of a listing
      sel[i]   = pend_r[i] && !acc;
      acc      = acc || pend_r[i];
      sel_key  = sel_key | (cell_key[i] & {KEY_WIDTH{sel[i]}});
    end
    sw_v1 = lk_val;
  end

  always_comb begin
    logic                   emit;
    logic                   e_found, e_full, e_last;
    logic [VALUE_WIDTH-1:0] e_val;
    logic [KEY_WIDTH-1:0]   e_key;
    logic                   do_shift;
    logic [CAPACITY-1:0]    drop;
    logic                   acc;

    state_nxt   = state_r;
    occ_nxt     = occ_r;
    rmv_val_nxt = rmv_val_r;
    pend_nxt    = pend_r;

    emit     = 1'b0;
    e_found  = 1'b0;
    e_full   = 1'b0;
    e_last   = 1'b1;
    e_val    = '0;
    e_key    = '0;
    do_shift = 1'b0;
    drop     = '0;
    acc      = 1'b0;

    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i]     = '0;
      wr_val_d[i] = v_in;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_SET: begin
              emit = 1'b1;
              if (|khit) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  ctrl[i].wr_val = khit[i];
                end
              end else if (occ_r < CW'(CAPACITY)) begin
                // append at the first free slot
                for (int i = 0; i < CAPACITY; i++) begin
                  ctrl[i].wr_key = (occ_r == CW'(i));
                  ctrl[i].wr_val = (occ_r == CW'(i));
                end
                occ_nxt = occ_r + CW'(1);
              end else begin
                e_full = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              emit    = 1'b1;
              e_found = |khit;
              e_val   = lk_val;
            end
            CMD_REMOVE_KEY: begin
              emit     = 1'b1;
              drop     = khit;
              do_shift = 1'b1;
              if (|khit) begin
                occ_nxt = occ_r - CW'(1);
              end
            end
            CMD_REMOVE_VALUE: begin
              rmv_val_nxt = v_in;
              state_nxt   = S_RMV;
            end
            CMD_KEYS_WITH_VAL: begin
              pend_nxt  = vhit;
              state_nxt = S_LIST;
            end
            CMD_SWAP: begin
              emit = 1'b1;
              if ((|khit) && (|k2hit)) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  ctrl[i].wr_val = khit[i] || k2hit[i];
                  wr_val_d[i]    = khit[i] ? sw_v2 : sw_v1;
                end
              end
            end
            CMD_CLEAR: begin
              emit    = 1'b1;
              occ_nxt = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_RMV: begin
        // drop the oldest matching entry each cycle until none is left
        if (|vhit) begin
          drop     = vhit;
          do_shift = 1'b1;
          occ_nxt  = occ_r - CW'(1);
        end else begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          emit = 1'b1;
          if (pend_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            e_found  = 1'b1;
            e_key    = sel_key;
            pend_nxt = pend_r & ~sel;
            e_last   = (pend_nxt == '0);
            if (e_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // cells at or right of the first dropped slot move one place left
    for (int i = 0; i < CAPACITY; i++) begin
      acc           = acc || drop[i];
      ctrl[i].shift = do_shift && acc;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = e_found;
      out_value_nxt = 32'(e_val);
      out_key_nxt   = 32'(e_key);
      out_count_nxt = 5'(occ_nxt);
      out_full_nxt  = e_full;
      out_last_nxt  = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rmv_val_r   <= rmv_val_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
    out_key_r   <= out_key_nxt;
    out_count_r <= out_count_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_value_out   = out_value_r;
  assign out_key_out     = out_key_r;
  assign out_entry_count = out_count_r;
  assign out_full_error  = out_full_r;
  assign out_last        = out_last_r;

  // entry count never passes the row length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // live keys are distinct, so a key compare hits at most one cell
  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(khit))
    else $error("duplicate live key");

  // value removal only ever shrinks the table
  a_rmv_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMV) |=> (occ_r <= $past(occ_r)))
    else $error("entry count grew during value removal");

  // a listing never runs with an undelivered beat being overwritten
  a_list_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST && out_valid_r && out_stall) |=> (pend_r == $past(pend_r)))
    else $error("listing advanced while output stalled");

endmodule

// ===== rtl/okvt_cell.sv =====
module okvt_cell import okvt_pkg::*; #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [KEY_WIDTH-1:0]   wr_key_d,
  input  logic [VALUE_WIDTH-1:0] wr_val_d,
  input  logic [KEY_WIDTH-1:0]   nb_key,
  input  logic [VALUE_WIDTH-1:0] nb_val,
  input  logic [KEY_WIDTH-1:0]   cmp_key,
  input  logic [KEY_WIDTH-1:0]   cmp_key2,
  input  logic [VALUE_WIDTH-1:0] cmp_val,
  output logic [KEY_WIDTH-1:0]   key_q,
  output logic [VALUE_WIDTH-1:0] val_q,
  output cell_hit_t              hit
);

  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // shifting and writing never happen in the same cycle
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end else begin
      if (ctrl.wr_key) begin
        key_r <= wr_key_d;
      end
      if (ctrl.wr_val) begin
        val_r <= wr_val_d;
      end
    end
  end

  assign key_q    = key_r;
  assign val_q    = val_r;
  assign hit.key  = (key_r == cmp_key);
  assign hit.key2 = (key_r == cmp_key2);
  assign hit.val  = (val_r == cmp_val);

endmodule
